[design/rau_pkg.sv]
// ---------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// actions, controller states and the command and status words
// ---------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int RES_NUM_W         = 33;
   localparam int RES_DEN_W         = 31;

   // actions carried by an input word
   typedef enum logic [2:0] {
      ACT_ADD    = 3'd0,
      ACT_SUB    = 3'd1,
      ACT_MUL    = 3'd2,
      ACT_DIV    = 3'd3,
      ACT_CMP    = 3'd4,
      ACT_NEG    = 3'd5,
      ACT_RECIP  = 3'd6,
      ACT_REDUCE = 3'd7
   } act_type;

   // which product the shared multiplier forms
   typedef enum logic [1:0] {
      MSEL_T0,
      MSEL_T1,
      MSEL_DEN
   } msel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_COMB,
      ST_CHECK,
      ST_GCD,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     load;
      logic     mul;
      msel_type mul_sel;
      logic     comb;
      logic     gcd_init;
      logic     gcd_step;
      logic     div_init;
      logic     div_step;
      logic     fin;
      logic     fin_err;
   } cmd_type;

   typedef struct packed {
      logic op_err;
      logic den_zero;
      logic num_zero;
      logic gcd_done;
   } status_type;

endpackage

`default_nettype wire

[design/rau_datapath.sv]
// ---------------------------------------------------------------------------
// rau_datapath: operand registers, shared multiplier, gcd and dividers
// forms the fraction, runs binary gcd, divides both parts, builds the result
// ---------------------------------------------------------------------------
`default_nettype none

module rau_datapath
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire cmd_type                         cmd,
   output status_type                           st,
   input  wire logic [2:0]                      req_action,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_b_den,
   output logic signed [RES_NUM_W-1:0]          rsp_res_num,
   output logic [RES_DEN_W-1:0]                 rsp_res_den,
   output logic                                 rsp_less,
   output logic                                 rsp_equal,
   output logic                                 rsp_greater,
   output logic                                 rsp_error
);

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * W;
   localparam int M  = 2 * W + 1;
   localparam int KW = $clog2(M + 1);
   localparam int XW = (M > RES_NUM_W) ? M : RES_NUM_W;
   localparam int DW = (M > RES_DEN_W) ? M : RES_DEN_W;

   act_type         act_ff;
   logic            an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   logic [W-1:0]    an_mag_ff, ad_mag_ff, bn_mag_ff, bd_mag_ff;
   logic            op_err_ff;
   logic            t0_neg_ff, t1_neg_ff, dn_neg_ff;
   logic [PW-1:0]   t0_mag_ff, t1_mag_ff, dn_mag_ff;
   logic            num_neg_ff, den_neg_ff;
   logic [M-1:0]    num_mag_ff, den_mag_ff;
   logic [M-1:0]    u_ff, v_ff, g_ff;
   logic [KW-1:0]   k_ff;
   logic [M-1:0]    qn_ff, qd_ff;
   logic [M:0]      rn_ff, rd_ff;

   logic            x_neg, y_neg, p_neg;
   logic [W-1:0]    x_mag, y_mag;
   logic [PW-1:0]   prod;
   logic [W-1:0]    one_mag;

   logic            an_neg_in, ad_neg_in, bn_neg_in, bd_neg_in;
   logic [W-1:0]    an_mag_in, ad_mag_in, bn_mag_in, bd_mag_in;

   logic            num_neg_in, den_neg_in;
   logic [M-1:0]    num_mag_in, den_mag_in;
   logic            sa_neg, sb_neg;
   logic [M-1:0]    sa_mag, sb_mag;

   logic [M-1:0]    u_in, v_in;
   logic [KW-1:0]   k_in;

   logic [M:0]      rn_sh, rd_sh, rn_in, rd_in;
   logic [M-1:0]    qn_in, qd_in;

   logic            res_neg;
   logic [XW-1:0]   nm_x, sn_x;
   logic [DW-1:0]   dm_x;

   assign one_mag = W'(1);

   // split input fields into sign and magnitude
   always_comb begin
      an_neg_in = req_a_num[W-1];
      ad_neg_in = req_a_den[W-1];
      bn_neg_in = req_b_num[W-1];
      bd_neg_in = req_b_den[W-1];
      an_mag_in = an_neg_in ? W'(-req_a_num) : W'(req_a_num);
      ad_mag_in = ad_neg_in ? W'(-req_a_den) : W'(req_a_den);
      bn_mag_in = bn_neg_in ? W'(-req_b_num) : W'(req_b_num);
      bd_mag_in = bd_neg_in ? W'(-req_b_den) : W'(req_b_den);
   end

   // operand selection for the shared multiplier
   always_comb begin
      x_neg = an_neg_ff;
      x_mag = an_mag_ff;
      y_neg = 1'b0;
      y_mag = one_mag;
      unique case (cmd.mul_sel)
         MSEL_T0: begin
            unique case (act_ff)
               ACT_ADD, ACT_SUB, ACT_CMP, ACT_DIV: begin
                  y_neg = bd_neg_ff;
                  y_mag = bd_mag_ff;
               end
               ACT_MUL: begin
                  y_neg = bn_neg_ff;
                  y_mag = bn_mag_ff;
               end
               ACT_RECIP: begin
                  x_neg = ad_neg_ff;
                  x_mag = ad_mag_ff;
               end
               default: begin
               end
            endcase
         end
         MSEL_T1: begin
            x_neg = bn_neg_ff;
            x_mag = bn_mag_ff;
            y_neg = ad_neg_ff;
            y_mag = ad_mag_ff;
         end
         MSEL_DEN: begin
            x_neg = ad_neg_ff;
            x_mag = ad_mag_ff;
            unique case (act_ff)
               ACT_ADD, ACT_SUB, ACT_CMP, ACT_MUL: begin
                  y_neg = bd_neg_ff;
                  y_mag = bd_mag_ff;
               end
               ACT_DIV: begin
                  y_neg = bn_neg_ff;
                  y_mag = bn_mag_ff;
               end
               ACT_RECIP: begin
                  x_neg = an_neg_ff;
                  x_mag = an_mag_ff;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      prod  = PW'(x_mag) * PW'(y_mag);
      p_neg = (x_neg ^ y_neg) && (prod != '0);
   end

   // combine the products into numerator and denominator
   always_comb begin
      sa_neg = t0_neg_ff;
      sa_mag = M'(t0_mag_ff);
      sb_mag = M'(t1_mag_ff);
      sb_neg = t1_neg_ff;
      if (act_ff == ACT_SUB || act_ff == ACT_CMP) begin
         sb_neg = !t1_neg_ff && (t1_mag_ff != '0);
      end
      num_neg_in = sa_neg;
      num_mag_in = sa_mag;
      unique case (act_ff)
         ACT_ADD, ACT_SUB, ACT_CMP: begin
            if (sa_neg == sb_neg) begin
               num_mag_in = sa_mag + sb_mag;
               num_neg_in = sa_neg;
            end else if (sa_mag >= sb_mag) begin
               num_mag_in = sa_mag - sb_mag;
               num_neg_in = sa_neg;
            end else begin
               num_mag_in = sb_mag - sa_mag;
               num_neg_in = sb_neg;
            end
            if (num_mag_in == '0) begin
               num_neg_in = 1'b0;
            end
         end
         ACT_NEG: begin
            num_neg_in = !t0_neg_ff && (t0_mag_ff != '0);
         end
         default: begin
         end
      endcase
      den_neg_in = dn_neg_ff;
      den_mag_in = M'(dn_mag_ff);
   end

   // one binary gcd step
   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      if (!u_ff[0] && !v_ff[0]) begin
         u_in = u_ff >> 1;
         v_in = v_ff >> 1;
         k_in = k_ff + KW'(1);
      end else if (!u_ff[0]) begin
         u_in = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_in = v_ff >> 1;
      end else if (u_ff > v_ff) begin
         u_in = u_ff - v_ff;
      end else begin
         v_in = v_ff - u_ff;
      end
   end

   // restoring division step on both parts
   always_comb begin
      rn_sh = {rn_ff[M-1:0], qn_ff[M-1]};
      rd_sh = {rd_ff[M-1:0], qd_ff[M-1]};
      rn_in = rn_sh;
      rd_in = rd_sh;
      qn_in = {qn_ff[M-2:0], 1'b0};
      qd_in = {qd_ff[M-2:0], 1'b0};
      if (rn_sh >= {1'b0, g_ff}) begin
         rn_in    = rn_sh - {1'b0, g_ff};
         qn_in[0] = 1'b1;
      end
      if (rd_sh >= {1'b0, g_ff}) begin
         rd_in    = rd_sh - {1'b0, g_ff};
         qd_in[0] = 1'b1;
      end
   end

   // signed result from the quotients
   always_comb begin
      res_neg = num_neg_ff ^ den_neg_ff;
      nm_x    = XW'(qn_ff);
      sn_x    = res_neg ? (~nm_x + XW'(1)) : nm_x;
      dm_x    = DW'(qd_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff    <= act_type'(req_action);
         an_neg_ff <= an_neg_in;
         ad_neg_ff <= ad_neg_in;
         bn_neg_ff <= bn_neg_in;
         bd_neg_ff <= bd_neg_in;
         an_mag_ff <= an_mag_in;
         ad_mag_ff <= ad_mag_in;
         bn_mag_ff <= bn_mag_in;
         bd_mag_ff <= bd_mag_in;
         op_err_ff <= (ad_mag_in == '0) ||
                      ((req_action <= 3'(ACT_CMP)) && (bd_mag_in == '0));
      end
      if (cmd.mul) begin
         unique case (cmd.mul_sel)
            MSEL_T0: begin
               t0_neg_ff <= p_neg;
               t0_mag_ff <= prod;
            end
            MSEL_T1: begin
               t1_neg_ff <= p_neg;
               t1_mag_ff <= prod;
            end
            default: begin
               dn_neg_ff <= p_neg;
               dn_mag_ff <= prod;
            end
         endcase
      end
      if (cmd.comb) begin
         num_neg_ff <= num_neg_in;
         num_mag_ff <= num_mag_in;
         den_neg_ff <= den_neg_in;
         den_mag_ff <= den_mag_in;
      end
      if (cmd.gcd_init) begin
         u_ff <= num_mag_ff;
         v_ff <= den_mag_ff;
         k_ff <= '0;
      end else if (cmd.gcd_step) begin
         u_ff <= u_in;
         v_ff <= v_in;
         k_ff <= k_in;
      end
      if (cmd.div_init) begin
         g_ff  <= u_ff << k_ff;
         qn_ff <= num_mag_ff;
         qd_ff <= den_mag_ff;
         rn_ff <= '0;
         rd_ff <= '0;
      end else if (cmd.div_step) begin
         qn_ff <= qn_in;
         qd_ff <= qd_in;
         rn_ff <= rn_in;
         rd_ff <= rd_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_res_num <= '0;
         rsp_res_den <= '0;
         rsp_less    <= 1'b0;
         rsp_equal   <= 1'b0;
         rsp_greater <= 1'b0;
         rsp_error   <= 1'b0;
      end else if (cmd.fin) begin
         rsp_less    <= 1'b0;
         rsp_equal   <= 1'b0;
         rsp_greater <= 1'b0;
         rsp_error   <= 1'b0;
         if (cmd.fin_err) begin
            rsp_res_num <= '0;
            rsp_res_den <= '0;
            rsp_error   <= 1'b1;
         end else if (num_mag_ff == '0) begin
            rsp_res_num <= '0;
            rsp_res_den <= RES_DEN_W'(1);
            rsp_equal   <= (act_ff == ACT_CMP);
         end else begin
            rsp_res_num <= sn_x[RES_NUM_W-1:0];
            rsp_res_den <= dm_x[RES_DEN_W-1:0];
            rsp_less    <= (act_ff == ACT_CMP) && res_neg;
            rsp_greater <= (act_ff == ACT_CMP) && !res_neg;
         end
      end
   end

   assign st.op_err   = op_err_ff;
   assign st.den_zero = (den_mag_ff == '0);
   assign st.num_zero = (num_mag_ff == '0);
   assign st.gcd_done = (u_ff == v_ff);

endmodule

`default_nettype wire

[design/rau_ctrl.sv]
// ---------------------------------------------------------------------------
// rau_ctrl: sequencing state machine of the rational arithmetic unit
// steps multiply, combine, gcd and divide phases and strobes the result
// ---------------------------------------------------------------------------
`default_nettype none

module rau_ctrl
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   output logic            rsp_valid,
   output cmd_type         cmd,
   input  wire status_type st
);

   localparam int M  = 2 * OPERAND_WIDTH + 1;
   localparam int CW = $clog2(M);

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      busy      = (state_ff != ST_IDLE);
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            if (st.op_err) begin
               cmd.fin     = 1'b1;
               cmd.fin_err = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cmd.mul     = 1'b1;
               cmd.mul_sel = MSEL_T0;
               state_in    = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul     = 1'b1;
            cmd.mul_sel = MSEL_T1;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul     = 1'b1;
            cmd.mul_sel = MSEL_DEN;
            state_in    = ST_COMB;
         end
         ST_COMB: begin
            cmd.comb = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (st.den_zero) begin
               cmd.fin     = 1'b1;
               cmd.fin_err = 1'b1;
               state_in    = ST_DONE;
            end else if (st.num_zero) begin
               cmd.fin  = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in     = ST_GCD;
            end
         end
         ST_GCD: begin
            if (st.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CW'(1);
            if (cnt_ff == CW'(M - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // result strobe lasts exactly one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // no new word is taken on the cycle a result leaves
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // gcd only runs on a nonzero fraction
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD) |-> (!st.num_zero && !st.den_zero))
      else $error("gcd entered with a zero part");

   // a load is followed by the operand check
   a_load_next: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_MUL0))
      else $error("load not followed by operand check");
`endif

endmodule

`default_nettype wire

[design/rational_arith_unit_top.sv]
// ---------------------------------------------------------------------------
// rational_arith_unit_top: signed fraction arithmetic with gcd reduction
// add, subtract, multiply, divide, compare, negate, reciprocal and reduce
// ---------------------------------------------------------------------------
// usage:
//   drive req_action and the four operand fields and raise start; the word is
//   taken at a rising edge with start high and busy low. busy stays high
//   until the result has been strobed, one word is in flight at a time.
//   the result appears on the rsp_ ports for exactly one cycle with
//   rsp_valid high; the receiver cannot stall it and must take it then.
// sequence, start edge to strobe:
//   an operand error goes from the operand check straight to the strobe. a
//   zero result or zero denominator runs the three products and the combine
//   step, then strobes. otherwise the binary gcd loop and the bit-serial
//   divider, one quotient bit per cycle for both parts, run before the
//   result word is built. the next word may be started in the cycle after
//   the strobe.
// reset: synchronous, clears the sequencer to idle and the result flags.
// ---------------------------------------------------------------------------
`default_nettype none

module rational_arith_unit_top
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [2:0]                      req_action,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_b_den,
   output logic                                 rsp_valid,
   output logic signed [RES_NUM_W-1:0]          rsp_res_num,
   output logic [RES_DEN_W-1:0]                 rsp_res_den,
   output logic                                 rsp_less,
   output logic                                 rsp_equal,
   output logic                                 rsp_greater,
   output logic                                 rsp_error
);

   cmd_type    cmd;
   status_type st;

   // sequencer
   rau_ctrl #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .st        (st)
   );

   // arithmetic
   rau_datapath #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .req_action  (req_action),
      .req_a_num   (req_a_num),
      .req_a_den   (req_a_den),
      .req_b_num   (req_b_num),
      .req_b_den   (req_b_den),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den),
      .rsp_less    (rsp_less),
      .rsp_equal   (rsp_equal),
      .rsp_greater (rsp_greater),
      .rsp_error   (rsp_error)
   );

endmodule

`default_nettype wire
